// File: rtl/core/vpts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voted period-to-speed core.
package vpts_pkg;

    localparam int COUNT_W   = 32;
    localparam int SPEED_W   = 48;
    localparam int OFFSET_W  = 8;
    localparam int MIN_W     = 16;
    localparam int PULSES_W  = 8;
    localparam int DISAG_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOTE_ENABLE    = 2'd0,
        REG_COUNT_OFFSET   = 2'd1,
        REG_MIN_SPEED_RPM  = 2'd2,
        REG_PULSES_PER_REV = 2'd3
    } cfg_reg_t;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd16;
    localparam logic [MIN_W-1:0]    MIN_RESET    = 16'd10;
    localparam logic [PULSES_W-1:0] PULSES_RESET = 8'd16;

    typedef struct packed {
        logic [COUNT_W-1:0] copy_first;
        logic [COUNT_W-1:0] copy_second;
        logic [COUNT_W-1:0] copy_third;
    } in_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_rpm_q8;
        logic               speed_zeroed;
        logic [DISAG_W-1:0] bytes_disagreed;
    } out_t;

    // control that rides alongside each word down the divider row
    typedef struct packed {
        logic               valid;
        logic               zeroed;
        logic [DISAG_W-1:0] disagree;
    } side_t;

endpackage

// File: rtl/core/vpts_front.sv
`timescale 1ns / 1ps
// Input stage: byte vote, offset check, divisor and dividend setup.
module vpts_front
    import vpts_pkg::*;
#(
    parameter int unsigned TIMEBASE_HZ   = 50000000,
    parameter int unsigned FRACTION_BITS = 8,
    parameter int unsigned NUM_W         = 50
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  in_t                 in_data,
    input  logic                vote_enable,
    input  logic [OFFSET_W-1:0] count_offset,
    input  logic [PULSES_W-1:0] pulses_per_rev,
    output side_t               side,
    output logic [COUNT_W-1:0]  den,
    output logic [NUM_W-1:0]    num
);

    localparam longint unsigned RPM_SCALE = 64'd60 * 64'(TIMEBASE_HZ);
    localparam int unsigned     SCALE_W   = $clog2(RPM_SCALE + 64'd1);
    localparam logic [SCALE_W-1:0] SCALE  = SCALE_W'(RPM_SCALE);

    logic                        valid_reg;
    logic                        zeroed_reg, zeroed_next;
    logic [DISAG_W-1:0]          disagree_reg, disagree_next;
    logic [COUNT_W-1:0]          den_reg, den_next;
    logic [NUM_W-1:0]            num_reg, num_next;
    logic [COUNT_W-1:0]          count;
    logic [3:0]                  byte_diff;
    logic [SCALE_W+PULSES_W-1:0] product;

    always_comb
    begin
        logic [7:0] ba, bb, bc;
        count     = in_data.copy_first;
        byte_diff = '0;
        for (int k = 0; k < 4; k++)
        begin
            ba = in_data.copy_first[k*8 +: 8];
            bb = in_data.copy_second[k*8 +: 8];
            bc = in_data.copy_third[k*8 +: 8];
            byte_diff[k] = !(ba == bb && ba == bc);
            // second and third outvote the first only when they agree
            if (vote_enable && ba != bb && bb == bc)
            begin
                count[k*8 +: 8] = bb;
            end
        end
        if (!vote_enable)
        begin
            byte_diff = '0;
        end
    end

    assign disagree_next = DISAG_W'(byte_diff[0]) + DISAG_W'(byte_diff[1])
                         + DISAG_W'(byte_diff[2]) + DISAG_W'(byte_diff[3]);
    assign zeroed_next   = (count <= COUNT_W'(count_offset));
    assign den_next      = count - COUNT_W'(count_offset);
    assign product       = SCALE * pulses_per_rev;
    assign num_next      = NUM_W'(product) << FRACTION_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            zeroed_reg   <= zeroed_next;
            disagree_reg <= disagree_next;
            den_reg      <= den_next;
            num_reg      <= num_next;
        end
    end

    assign side.valid    = valid_reg;
    assign side.zeroed   = zeroed_reg;
    assign side.disagree = disagree_reg;
    assign den           = den_reg;
    assign num           = num_reg;

endmodule

// File: rtl/core/vpts_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: resolves one quotient bit per word.
module vpts_div_cell
    import vpts_pkg::*;
#(
    parameter int unsigned NUM_W = 50
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  side_t              side_in,
    input  logic [COUNT_W-1:0] den_in,
    input  logic [COUNT_W-1:0] rem_in,
    input  logic [NUM_W-1:0]   nq_in,
    output side_t              side_out,
    output logic [COUNT_W-1:0] den_out,
    output logic [COUNT_W-1:0] rem_out,
    output logic [NUM_W-1:0]   nq_out
);

    logic               valid_reg;
    logic [DISAG_W-1:0] disagree_reg;
    logic               zeroed_reg;
    logic [COUNT_W-1:0] den_reg;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]   nq_reg, nq_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               fits;

    // nq holds the unused dividend bits on top, quotient bits shift in below
    assign trial    = {rem_in, nq_in[NUM_W-1]};
    assign fits     = (trial >= {1'b0, den_in});
    assign diff     = trial - {1'b0, den_in};
    assign rem_next = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    assign nq_next  = {nq_in[NUM_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= side_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            zeroed_reg   <= side_in.zeroed;
            disagree_reg <= side_in.disagree;
            den_reg      <= den_in;
            rem_reg      <= rem_next;
            nq_reg       <= nq_next;
        end
    end

    assign side_out.valid    = valid_reg;
    assign side_out.zeroed   = zeroed_reg;
    assign side_out.disagree = disagree_reg;
    assign den_out           = den_reg;
    assign rem_out           = rem_reg;
    assign nq_out            = nq_reg;

endmodule

// File: rtl/core/vpts_out_buf.sv
`timescale 1ns / 1ps
// Result finishing (saturate, minimum check) and two-entry output buffer.
module vpts_out_buf
    import vpts_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 8,
    parameter int unsigned NUM_W         = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  side_t            side,
    input  logic [NUM_W-1:0] quot,
    input  logic [MIN_W-1:0] min_speed_rpm,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data
);

    logic [SPEED_W-1:0] sat;
    logic [SPEED_W-1:0] min_scaled;
    logic               below;
    out_t               word_next;
    out_t               entry0_reg, entry1_reg;
    logic [1:0]         count_reg, count_next;
    logic               push, pop;

    generate
        if (NUM_W > SPEED_W)
        begin : g_sat
            assign sat = (|quot[NUM_W-1:SPEED_W]) ? '1 : quot[SPEED_W-1:0];
        end
        else
        begin : g_nosat
            assign sat = SPEED_W'(quot);
        end
    endgenerate

    assign min_scaled = SPEED_W'(min_speed_rpm) << FRACTION_BITS;
    assign below      = (sat < min_scaled);

    assign word_next.speed_zeroed    = side.zeroed || below;
    assign word_next.speed_rpm_q8    = word_next.speed_zeroed ? '0 : sat;
    assign word_next.bytes_disagreed = side.disagree;

    // the divider row only moves while there is room for its last word
    assign advance   = (count_reg != 2'd2);
    assign push      = advance && side.valid;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry0_reg <= (count_reg == 2'd2) ? entry1_reg : word_next;
            if (push && count_reg == 2'd2)
            begin
                entry1_reg <= word_next;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                entry0_reg <= word_next;
            end
            else
            begin
                entry1_reg <= word_next;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("pushed word not held");

    a_zeroed_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.speed_zeroed |-> out_data.speed_rpm_q8 == '0)
        else $error("zeroed word carries a speed");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && !pop |=> count_reg == 2'd2)
        else $error("full buffer lost a word");

endmodule

// File: rtl/core/voted_period_to_speed_core.sv
`timescale 1ns / 1ps
// Top level: config registers, input stage, divider cell row, output buffer.
//
// Usage: each input word carries three reads of a 32-bit period count.
// With vote_enable set each byte is majority-voted, otherwise the first
// read is used. The word comes out as speed in rpm with FRACTION_BITS
// fraction bits, a zeroed flag and the count of disagreeing bytes.
// Config: cfg_we writes cfg_data into register cfg_index at once; write only
// while no word is in flight.
// Throughput: one word per cycle while the output buffer is not full. A word
// passes the input register, then the row of NUM_W division cells, each
// resolving one quotient bit, then the output buffer before out_valid.
// Stalls: a two-entry buffer sits at the output; the cell row and in_ready
// freeze only when both entries hold unread words, so input keeps flowing
// while a single result waits.
// Reset: clears all valid state and loads the register defaults
// (vote off, offset 16, minimum 10 rpm, 16 pulses per revolution).
module voted_period_to_speed_core
    import vpts_pkg::*;
#(
    parameter int unsigned TIMEBASE_HZ   = 50000000,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam longint unsigned RPM_SCALE = 64'd60 * 64'(TIMEBASE_HZ);
    localparam int unsigned     SCALE_W   = $clog2(RPM_SCALE + 64'd1);
    localparam int unsigned     NUM_W     = SCALE_W + PULSES_W + FRACTION_BITS;

    logic                vote_enable_reg;
    logic [OFFSET_W-1:0] count_offset_reg;
    logic [MIN_W-1:0]    min_speed_reg;
    logic [PULSES_W-1:0] pulses_reg;
    logic                advance;

    side_t              side_c [0:NUM_W];
    logic [COUNT_W-1:0] den_c  [0:NUM_W];
    logic [COUNT_W-1:0] rem_c  [0:NUM_W];
    logic [NUM_W-1:0]   nq_c   [0:NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_enable_reg  <= 1'b0;
            count_offset_reg <= OFFSET_RESET;
            min_speed_reg    <= MIN_RESET;
            pulses_reg       <= PULSES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VOTE_ENABLE:    vote_enable_reg  <= cfg_data[0];
                REG_COUNT_OFFSET:   count_offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_MIN_SPEED_RPM:  min_speed_reg    <= cfg_data[MIN_W-1:0];
                REG_PULSES_PER_REV: pulses_reg       <= cfg_data[PULSES_W-1:0];
                default:            ;
            endcase
        end
    end

    assign in_ready = advance;

    vpts_front #(
        .TIMEBASE_HZ  (TIMEBASE_HZ),
        .FRACTION_BITS(FRACTION_BITS),
        .NUM_W        (NUM_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .in_data       (in_data),
        .vote_enable   (vote_enable_reg),
        .count_offset  (count_offset_reg),
        .pulses_per_rev(pulses_reg),
        .side          (side_c[0]),
        .den           (den_c[0]),
        .num           (nq_c[0])
    );

    assign rem_c[0] = '0;

    generate
        for (genvar i = 0; i < NUM_W; i++)
        begin : g_cell
            vpts_div_cell #(
                .NUM_W(NUM_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .side_in (side_c[i]),
                .den_in  (den_c[i]),
                .rem_in  (rem_c[i]),
                .nq_in   (nq_c[i]),
                .side_out(side_c[i+1]),
                .den_out (den_c[i+1]),
                .rem_out (rem_c[i+1]),
                .nq_out  (nq_c[i+1])
            );
        end
    endgenerate

    vpts_out_buf #(
        .FRACTION_BITS(FRACTION_BITS),
        .NUM_W        (NUM_W)
    ) u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .side         (side_c[NUM_W]),
        .quot         (nq_c[NUM_W]),
        .min_speed_rpm(min_speed_reg),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
